// ===== design/rtcwr_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcwr_pkg: shared types and constants for the rain tip counter
// Payload structs, function codes, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package rtcwr_pkg;

	localparam int BUCKETS = 12;
	localparam int IDX_W   = $clog2(BUCKETS);
	localparam int CNT_W   = $clog2(BUCKETS + 1);
	localparam int TIME_W  = 48;
	localparam int BKT_W   = 16;
	localparam int SUM_W   = BKT_W + $clog2(BUCKETS);
	localparam int TOTAL_W = 32;

	localparam int TOT_OUT_W  = 36;
	localparam int RATE_OUT_W = 30;
	localparam int SCALE_W    = 10;   // depth * 60 fits in 10 bits
	localparam int PROD_W     = (SUM_W + SCALE_W > RATE_OUT_W) ? SUM_W + SCALE_W
		: RATE_OUT_W + 1;

	localparam logic [RATE_OUT_W-1:0] RATE_MAX = '1;
	localparam logic [5:0] MIN_PER_HR = 6'd60;

	localparam logic [15:0] LOCKOUT_RST = 16'd5;
	localparam logic [15:0] PERIOD_RST  = 16'd5000;
	localparam logic [3:0]  DEPTH_RST   = 4'd2;

	typedef enum logic [1:0] {
		FUNC_TIP   = 2'd0,
		FUNC_TOTAL = 2'd1,
		FUNC_RATE  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		CFG_LOCKOUT = 2'd0,
		CFG_PERIOD  = 2'd1,
		CFG_DEPTH   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic                  tip_accepted;
		logic [TOT_OUT_W-1:0]  total_tenths_mm;
		logic [RATE_OUT_W-1:0] rate_tenths_mm_per_hr;
	} out_item_t;

	// ring control from the sequencer
	typedef struct packed {
		logic inc;   // count one tip in the current bucket
		logic adv;   // step to the next bucket and clear it
	} ring_cmd_t;

endpackage

// ===== design/rtcwr_sub.sv =====
// ----------------------------------------------------------------------------
// rtcwr_sub: shared 48-bit subtract and compare unit
// Gives a - b and a borrow flag (a < b); reused for every time check.
// ----------------------------------------------------------------------------
module rtcwr_sub import rtcwr_pkg::*; (
	input  logic [TIME_W-1:0] a,
	input  logic [TIME_W-1:0] b,
	output logic [TIME_W-1:0] diff,
	output logic              borrow
);

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// ===== design/rtcwr_ring.sv =====
// ----------------------------------------------------------------------------
// rtcwr_ring: ring of tip buckets
// Saturating increment of the current bucket, advance with clear, one read port.
// ----------------------------------------------------------------------------
module rtcwr_ring import rtcwr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ring_cmd_t        cmd,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [BKT_W-1:0] rd_data
);

	logic [BKT_W-1:0] bkt_q [BUCKETS];
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_nxt;

	assign idx_nxt = (idx_q == IDX_W'(BUCKETS - 1)) ? '0 : idx_q + 1'b1;
	assign rd_data = bkt_q[rd_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			for (int i = 0; i < BUCKETS; i++) begin
				bkt_q[i] <= '0;
			end
		end else if (cmd.adv) begin
			idx_q          <= idx_nxt;
			bkt_q[idx_nxt] <= '0;
		end else if (cmd.inc) begin
			if (bkt_q[idx_q] != '1) begin
				bkt_q[idx_q] <= bkt_q[idx_q] + 1'b1;
			end
		end
	end

endmodule

// ===== design/rain_tip_counter_window_rate_unit.sv =====
// ----------------------------------------------------------------------------
// rain_tip_counter_window_rate_unit: tipping-bucket rain gauge counter
// Debounced tip counting, read-and-clear total, and a sliding-window rate
// over a ring of buckets, run by a small sequencer around one subtractor.
// ----------------------------------------------------------------------------
//
//  channel | signals                        | direction | beat
//  --------+--------------------------------+-----------+--------------------------
//  in      | in_valid, in_stall, in_data    | in        | valid & !stall
//  out     | out_valid, out_stall, out_data | out       | valid & !stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in | valid & ready
//
// A tip takes a time check and, unless the stamp is behind the last tip, a
// lockout check; a total read or unused code goes to the output; a rate read
// steps the ring per bucket period elapsed (at most BUCKETS, none when the stamp
// is behind the last advance), then sums all buckets; the 48-bit subtractor does
// one period subtraction per cycle and the bucket sum reads one bucket per cycle.
// in_stall is high while an item is in work.
// A finished result sits in the output register; the next item is accepted
// while it waits for out_stall to drop.
// Reset clears all counters, the ring and the timestamps and loads the
// register defaults; no clearing pass is needed.
module rain_tip_counter_window_rate_unit import rtcwr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_TIP_LOCK,
		S_ADV,
		S_SUM,
		S_MUL,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] lockout_q;
	logic [15:0] period_q;
	logic [3:0]  depth_q;

	// block state
	logic [TOTAL_W-1:0] total_q;
	logic [TIME_W-1:0]  last_tip_q;
	logic [TIME_W-1:0]  last_adv_q;

	// item in work
	logic [1:0]        func_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] rem_q;      // remaining elapsed time / lockout diff
	logic [CNT_W-1:0]  step_q;     // buckets entered so far
	logic              adv_any_q;
	logic [IDX_W-1:0]  sidx_q;     // bucket being summed
	logic [SUM_W-1:0]  sum_q;
	out_item_t         res_q;

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	// shared subtractor
	logic [TIME_W-1:0] sub_a;
	logic [TIME_W-1:0] sub_b;
	logic [TIME_W-1:0] sub_diff;
	logic              sub_borrow;

	ring_cmd_t        ring_cmd;
	logic [BKT_W-1:0] ring_rd;

	logic [15:0]           period_eff;
	logic [SCALE_W-1:0]    scale;
	logic [PROD_W-1:0]     rate_prod;
	logic [RATE_OUT_W-1:0] rate_sat;
	logic [TOT_OUT_W-1:0]  total_prod;
	logic                  in_beat;
	logic                  cfg_beat;

	assign in_beat   = in_valid && !in_stall;
	assign cfg_beat  = cfg_valid && cfg_ready;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a zero period behaves as one millisecond
	assign period_eff = (period_q == '0) ? 16'd1 : period_q;

	// depth * 60, then one multiply by the bucket sum
	assign scale     = SCALE_W'(depth_q) * SCALE_W'(MIN_PER_HR);
	assign rate_prod = PROD_W'(sum_q) * PROD_W'(scale);
	assign rate_sat  = (rate_prod > PROD_W'(RATE_MAX)) ? RATE_MAX
		: rate_prod[RATE_OUT_W-1:0];

	assign total_prod = TOT_OUT_W'(total_q) * TOT_OUT_W'(depth_q);

	// operand select for the subtractor
	always_comb begin
		sub_a = now_q;
		sub_b = last_tip_q;
		case (state_q)
			S_START: begin
				if (func_q == FUNC_RATE) begin
					sub_b = last_adv_q;
				end
			end
			S_TIP_LOCK: begin
				sub_a = rem_q;
				sub_b = TIME_W'(lockout_q);
			end
			S_ADV: begin
				sub_a = rem_q;
				sub_b = TIME_W'(period_eff);
			end
			default: begin
				sub_a = now_q;
				sub_b = last_tip_q;
			end
		endcase
	end

	rtcwr_sub u_sub (
		.a      (sub_a),
		.b      (sub_b),
		.diff   (sub_diff),
		.borrow (sub_borrow)
	);

	always_comb begin
		ring_cmd.inc = (state_q == S_TIP_LOCK) && !sub_borrow;
		ring_cmd.adv = (state_q == S_ADV) && !sub_borrow && (step_q != CNT_W'(BUCKETS));
	end

	rtcwr_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ring_cmd),
		.rd_addr (sidx_q),
		.rd_data (ring_rd)
	);

	// configuration registers; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= LOCKOUT_RST;
			period_q  <= PERIOD_RST;
			depth_q   <= DEPTH_RST;
		end else if (cfg_beat) begin
			case (cfg_index)
				CFG_LOCKOUT: lockout_q <= cfg_data;
				CFG_PERIOD:  period_q  <= cfg_data;
				CFG_DEPTH:   depth_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer, block state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			last_tip_q  <= '0;
			last_adv_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			res_q       <= '0;
			func_q      <= '0;
			now_q       <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			adv_any_q   <= 1'b0;
			sidx_q      <= '0;
			sum_q       <= '0;
		end else begin
			// S_OUT reloads the register itself when it is free
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						func_q  <= in_data.func;
						now_q   <= in_data.now_ms;
						res_q   <= '0;
						state_q <= S_START;
					end
				end
				S_START: begin
					case (func_q)
						FUNC_TIP: begin
							// time going backwards rejects the tip
							if (sub_borrow) begin
								state_q <= S_OUT;
							end else begin
								rem_q   <= sub_diff;
								state_q <= S_TIP_LOCK;
							end
						end
						FUNC_TOTAL: begin
							res_q.total_tenths_mm <= total_prod;
							total_q               <= '0;
							state_q               <= S_OUT;
						end
						FUNC_RATE: begin
							rem_q     <= sub_diff;
							step_q    <= '0;
							adv_any_q <= 1'b0;
							sidx_q    <= '0;
							sum_q     <= '0;
							// time going backwards skips the advance
							state_q   <= sub_borrow ? S_SUM : S_ADV;
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_TIP_LOCK: begin
					if (!sub_borrow) begin
						res_q.tip_accepted <= 1'b1;
						last_tip_q         <= now_q;
						if (total_q != '1) begin
							total_q <= total_q + 1'b1;
						end
					end
					state_q <= S_OUT;
				end
				S_ADV: begin
					if (ring_cmd.adv) begin
						rem_q     <= sub_diff;
						step_q    <= step_q + 1'b1;
						adv_any_q <= 1'b1;
					end else begin
						// remainder of the elapsed time is dropped
						if (adv_any_q) begin
							last_adv_q <= now_q;
						end
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					sum_q <= sum_q + SUM_W'(ring_rd);
					if (sidx_q == IDX_W'(BUCKETS - 1)) begin
						sidx_q  <= '0;
						state_q <= S_MUL;
					end else begin
						sidx_q <= sidx_q + 1'b1;
					end
				end
				S_MUL: begin
					res_q.rate_tenths_mm_per_hr <= rate_sat;
					state_q                     <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// an accepted item keeps the input stalled on the next cycle
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> in_stall)
		else $error("input not stalled after accepted beat");

	// at most one result field is nonzero
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($countones({out_data.tip_accepted, |out_data.total_tenths_mm,
			|out_data.rate_tenths_mm_per_hr}) <= 1))
		else $error("more than one result field set");

	// the ring never advances more than one full turn per read
	a_step_cap: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= CNT_W'(BUCKETS))
		else $error("ring advanced past one turn");

	// ring increment and advance never collide
	a_ring_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(ring_cmd.inc && ring_cmd.adv))
		else $error("ring increment and advance together");

	// a new result only lands once the previous one is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(out_q))
		else $error("pending result overwritten");
`endif

endmodule

// ===== tb/rain_gauge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rain_gauge_checker: result predictor and compare for the rain tip counter
// Snoops the cfg, in and out channels, predicts each result from its own copy
// of the gauge state and compares every out beat with the oldest prediction.
// ----------------------------------------------------------------------------
module rain_gauge_checker import rtcwr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output int          pending
);

	localparam int REPORT_CAP = 200;

	logic [15:0] lockout_ms;
	logic [15:0] period_ms;
	logic [3:0]  depth_tenths;
	logic [31:0] tip_total;
	logic [47:0] last_tip_ms;
	logic [47:0] last_adv_ms;
	logic [15:0] ring_cnt [BUCKETS];
	int          ring_pos;
	out_item_t   expected_q [$];
	out_item_t   want;
	int          err_total;

	// advances the gauge state by one beat and returns the result it gives
	function automatic out_item_t predict_gauge(input in_item_t beat);
		out_item_t   res;
		logic [63:0] stamp;
		logic [63:0] per;
		logic [63:0] steps;
		logic [63:0] ring_sum;
		logic [63:0] prod;
		res   = '0;
		stamp = 64'(beat.now_ms);
		case (beat.func)
		FUNC_TIP: begin
			if (stamp >= 64'(last_tip_ms) &&
				stamp - 64'(last_tip_ms) >= 64'(lockout_ms)) begin
				if (tip_total != '1)
					tip_total = tip_total + 32'd1;
				if (ring_cnt[ring_pos] != '1)
					ring_cnt[ring_pos] = ring_cnt[ring_pos] + 16'd1;
				last_tip_ms      = beat.now_ms;
				res.tip_accepted = 1'b1;
			end
		end
		FUNC_TOTAL: begin
			prod                = 64'(tip_total) * 64'(depth_tenths);
			res.total_tenths_mm = prod[TOT_OUT_W-1:0];
			tip_total           = '0;
		end
		FUNC_RATE: begin
			per = (period_ms == '0) ? 64'd1 : 64'(period_ms);
			if (stamp >= 64'(last_adv_ms) && stamp - 64'(last_adv_ms) >= per) begin
				steps = (stamp - 64'(last_adv_ms)) / per;
				if (steps > 64'(BUCKETS))
					steps = 64'(BUCKETS);
				for (int k = 0; k < int'(steps); k++) begin
					ring_pos           = (ring_pos + 1) % BUCKETS;
					ring_cnt[ring_pos] = '0;
				end
				last_adv_ms = beat.now_ms;
			end
			ring_sum = '0;
			for (int k = 0; k < BUCKETS; k++)
				ring_sum = ring_sum + 64'(ring_cnt[k]);
			prod = ring_sum * 64'(depth_tenths) * 64'(MIN_PER_HR);
			if (prod > 64'(RATE_MAX))
				prod = 64'(RATE_MAX);
			res.rate_tenths_mm_per_hr = prod[RATE_OUT_W-1:0];
		end
		default: ;
		endcase
		return res;
	endfunction

	task automatic check_field(input string label, input logic [63:0] exp_v,
		input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			err_total++;
			if (err_total <= REPORT_CAP)
				$display("%0t: %s expected %0d actual %0d", $time, label, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_ms   = LOCKOUT_RST;
			period_ms    = PERIOD_RST;
			depth_tenths = DEPTH_RST;
			tip_total    = '0;
			last_tip_ms  = '0;
			last_adv_ms  = '0;
			ring_pos     = 0;
			foreach (ring_cnt[k])
				ring_cnt[k] = '0;
			expected_q.delete();
			err_total      = 0;
			mismatch_count <= 0;
			pending        <= 0;
		end else begin
			// writes must land only while the unit is idle (the unit does not enforce it), so order here is free
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_LOCKOUT: lockout_ms   = cfg_data;
				CFG_PERIOD:  period_ms    = cfg_data;
				CFG_DEPTH:   depth_tenths = cfg_data[3:0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_gauge(in_data));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					err_total++;
					if (err_total <= REPORT_CAP)
						$display("%0t: result with nothing expected, actual %0d %0d %0d",
							$time, out_data.tip_accepted, out_data.total_tenths_mm,
							out_data.rate_tenths_mm_per_hr);
				end else begin
					want = expected_q.pop_front();
					check_field("tip_accepted", 64'(want.tip_accepted),
						64'(out_data.tip_accepted));
					check_field("total_tenths_mm", 64'(want.total_tenths_mm),
						64'(out_data.total_tenths_mm));
					check_field("rate_tenths_mm_per_hr", 64'(want.rate_tenths_mm_per_hr),
						64'(out_data.rate_tenths_mm_per_hr));
				end
			end
			mismatch_count <= err_total;
			pending        <= expected_q.size();
		end
	end

endmodule

// ===== tb/rain_tip_counter_window_rate_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rain_tip_counter_window_rate_unit_tb: stimulus and verdict for the gauge
// Drives tip, total and rate beats under several register settings with
// random idling on both channels; the checker beside the unit predicts and
// compares every result and hands back its mismatch count.
// ----------------------------------------------------------------------------
module rain_tip_counter_window_rate_unit_tb;
	import rtcwr_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;  // several times the slowest clean run
	localparam int SETTLE      = 40;         // longer than the worst rate read: a full turn of steps plus the bucket sum
	localparam int LONG_HOLD   = 400;        // receiver hold-off, long enough to back up
	localparam int PHASE_BEATS = 275;        // beats per register setting

	// unused selector code: the unit must ignore it and return zeros
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int          mismatch_count;
	int          pending;
	int          cycle_count;

	bit          hold_req = 1'b0;  // asks the receiver for one long hold-off
	bit          tx_quiet;         // sender runs with no gaps while set
	bit          rx_quiet;         // receiver never stalls while set
	logic [47:0] gauge_ms;         // uptime of the well-formed event stream
	int unsigned cur_lockout;      // register mirror, used only to shape stimulus
	int unsigned cur_period;       // effective bucket period (0 reads as 1)

	rain_tip_counter_window_rate_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rain_gauge_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// hard stop in case the unit hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// full 48-bit stamp; only used where the unit ignores the time
	function automatic logic [47:0] rand_stamp();
		return 48'({$urandom, $urandom});
	endfunction

	// next tip time: mostly straddling the lockout edge, sometimes far ahead
	function automatic logic [47:0] step_tip_ms();
		int r;
		longint unsigned d;
		r = $urandom_range(0, 9);
		if (r < 6)
			d = $urandom_range(0, 2 * cur_lockout + 2);
		else if (r < 8)
			d = (cur_lockout > 0) ? cur_lockout - $urandom_range(0, 1) : 0;
		else
			d = $urandom_range(0, 3 * cur_period);
		gauge_ms = gauge_ms + 48'(d);
		return gauge_ms;
	endfunction

	// next rate read time: under a period, a few periods, or 4 to 15 periods (past a full turn at the top)
	function automatic logic [47:0] step_rate_ms();
		int r;
		longint unsigned d;
		r = $urandom_range(0, 9);
		if (r < 3)
			d = $urandom_range(0, cur_period - 1);
		else if (r < 8)
			d = longint'(cur_period) * $urandom_range(1, 3) + $urandom_range(0, cur_period - 1);
		else
			d = longint'(cur_period) * $urandom_range(4, 15);
		gauge_ms = gauge_ms + 48'(d);
		return gauge_ms;
	endfunction

	// a stamp behind the stream: rate reads do not step, and tips behind the last tip get rejected
	function automatic logic [47:0] back_stamp();
		if (gauge_ms > 48'd2000)
			return gauge_ms - 48'($urandom_range(1, 2000));
		return 48'd0;
	endfunction

	// one beat on the in channel; returns at the edge that takes it
	task automatic send_item(input logic [1:0] code, input logic [47:0] stamp);
		int       gap;
		in_item_t beat;
		if ($urandom_range(0, 49) == 0)
			tx_quiet = !tx_quiet;
		gap         = pick_gap(tx_quiet);
		beat.func   = code;
		beat.now_ms = stamp;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stop offering and wait until every expected result is out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// new register setting; the unit must be idle, so drain and settle first
	task automatic write_config(input logic [15:0] lockout, input logic [15:0] period,
		input logic [3:0] depth);
		cfg_idx_t    reg_list [3];
		logic [15:0] vals [3];
		reg_list = '{CFG_LOCKOUT, CFG_PERIOD, CFG_DEPTH};
		vals     = '{lockout, period, {12'd0, depth}};
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_list[k];
			cfg_data  <= vals[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid   <= 1'b0;
		cur_lockout = lockout;
		cur_period  = (period == 16'd0) ? 1 : period;
	endtask

	// Random part: showers of tips closed by a rate read, with noise between
	// them (total reads at random stamps, the unused selector, late stamps).
	// hold_at / pause_at trigger the receiver hold-off and a full drain once.
	task automatic run_phase(input int n_beats, input int hold_at, input int pause_at);
		int sent;
		int shower;
		sent = 0;
		while (sent < n_beats) begin
			shower = $urandom_range(1, 12);
			repeat (shower) begin
				send_item(FUNC_TIP, step_tip_ms());
				sent++;
			end
			send_item(FUNC_RATE, step_rate_ms());
			sent++;
			case ($urandom_range(0, 7))
			0, 1: begin
				send_item(FUNC_TOTAL, rand_stamp());
				sent++;
			end
			2: send_item(FUNC_UNUSED, rand_stamp());
			3: begin
				send_item($urandom_range(0, 1) ? FUNC_TIP : FUNC_RATE, back_stamp());
				sent++;
			end
			default: ;
			endcase
			if (hold_at >= 0 && sent >= hold_at) begin
				hold_req = 1'b1;  // sender keeps offering while the receiver holds
				hold_at  = -1;
			end
			if (pause_at >= 0 && sent >= pause_at) begin
				wait_drained();
				pause_at = -1;
			end
		end
	endtask

	// receiver: random stall runs, quiet stretches, and one long hold-off
	initial begin
		int stall_len;
		out_stall = 1'b0;
		rx_quiet  = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if ($urandom_range(0, 63) == 0)
					rx_quiet = !rx_quiet;
				stall_len = pick_gap(rx_quiet);
				out_stall <= (stall_len > 0);
				repeat ((stall_len > 0) ? stall_len : 1) @(posedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_LOCKOUT;
		cfg_data    = '0;
		tx_quiet    = 1'b0;
		gauge_ms    = '0;
		cur_lockout = LOCKOUT_RST;
		cur_period  = PERIOD_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset registers: lockout 5, period 5000, depth 2
		send_item(FUNC_TIP, 48'd0);          // same stamp as reset tip time: rejected
		send_item(FUNC_TIP, 48'd4);          // one short of lockout
		send_item(FUNC_TIP, 48'd5);          // exactly lockout: counted
		send_item(FUNC_TIP, 48'd9);
		send_item(FUNC_TIP, 48'd10);
		send_item(FUNC_TIP, 48'd10);         // repeated stamp
		send_item(FUNC_RATE, 48'd4999);      // under one period: ring stays put
		send_item(FUNC_RATE, 48'd5000);      // exactly one period: one step
		send_item(FUNC_TOTAL, '1);           // read and clear, stamp ignored
		send_item(FUNC_TOTAL, 48'd0);        // cleared total reads zero
		send_item(FUNC_UNUSED, '1);
		send_item(FUNC_UNUSED, 48'd0);
		send_item(FUNC_TIP, 48'd20000);
		send_item(FUNC_RATE, 48'd4000);      // behind last advance: no step
		send_item(FUNC_TIP, 48'd19000);      // time going backwards: rejected
		send_item(FUNC_RATE, 48'd155000);    // 30 periods, capped at one full turn
		send_item(FUNC_TIP, 48'd155000);
		send_item(FUNC_TIP, 48'd155005);
		send_item(FUNC_RATE, 48'd155005);
		send_item(FUNC_TOTAL, 48'd155005);
		gauge_ms = 48'd155005;

		run_phase(PHASE_BEATS, -1, -1);

		// no lockout, shortest period, deepest tip
		write_config(16'd0, 16'd1, 4'd15);
		run_phase(PHASE_BEATS, -1, -1);

		// widest lockout and period; the long receiver hold-off lands here
		write_config(16'hFFFF, 16'hFFFF, 4'd1);
		run_phase(PHASE_BEATS, 40, -1);

		// zero period acts as one, zero depth reads as no rain; sender pause here
		write_config(16'd0, 16'd0, 4'd0);
		run_phase(PHASE_BEATS, -1, 100);

		write_config(16'd1, 16'd7, 4'd15);
		run_phase(PHASE_BEATS, -1, -1);

		write_config(16'd12, 16'd250, 4'd9);
		run_phase(PHASE_BEATS, -1, -1);

		write_config(16'($urandom_range(0, 40)), 16'($urandom_range(1, 3000)),
			4'($urandom_range(1, 15)));
		run_phase(PHASE_BEATS, -1, -1);

		// top of the time range: tip there, then a rate read a full turn away
		send_item(FUNC_TIP, '1);
		send_item(FUNC_RATE, '1);
		send_item(FUNC_TOTAL, '1);

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/rtcwr_pkg.sv
design/rtcwr_sub.sv
design/rtcwr_ring.sv
design/rain_tip_counter_window_rate_unit.sv
tb/rain_gauge_checker.sv
tb/rain_tip_counter_window_rate_unit_tb.sv
